/* hw/rtl/ptpd_pkg.sv */
package ptpd_pkg;

   localparam int TRIG_ITER = 30;
   localparam int DIV_BITS  = 32;

   localparam logic CSR_IDX_SMALL_ANGLE = 1'b0;
   localparam logic [15:0] SMALL_ANGLE_RESET = 16'd1;

   localparam logic signed [31:0] Q30_ONE   = 32'sd1073741824;
   localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;
   localparam logic [31:0] RECIP_TWO_PI     = 32'd2734261100;
   localparam logic [31:0] RECIP_THREE      = 32'hAAAAAAAB;
   localparam logic signed [51:0] TWO_PI_W  = 52'sd26986075409;
   localparam logic signed [39:0] TWO_PI_R  = 40'sd26986075409;
   localparam logic signed [39:0] PI_R      = 40'sd13493037705;
   localparam logic signed [39:0] PI_Q30_R  = 40'sd3373259426;
   localparam logic signed [39:0] HALF_PI_R = 40'sd1686629713;

   localparam logic [31:0] ATAN_Q30 [32] = '{
      32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
      32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
      32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
      32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
      32'd127, 32'd63, 32'd31, 32'd15, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
   };

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] th;
      logic               series;
      logic [30:0]        ser_s;
   } ctx_type;

   typedef struct packed {
      ctx_type            ctx;
      logic signed [31:0] cs;
      logic signed [31:0] sn;
   } trig_type;

   typedef struct packed {
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] s;
      logic signed [31:0] c;
      logic signed [31:0] cs;
      logic signed [31:0] sn;
   } coef_type;

   function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
      if (v > 34'sd1073741824) begin
         return Q30_ONE;
      end
      if (v < -34'sd1073741824) begin
         return -Q30_ONE;
      end
      return 32'(v);
   endfunction

endpackage

/* hw/rtl/ptpd_scale.sv */
module ptpd_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic signed [31:0]  vel_forward,
   input  logic signed [31:0]  vel_side,
   input  logic signed [31:0]  vel_turn,
   input  logic [15:0]         time_step,
   input  logic [15:0]         limit,
   output logic                out_valid,
   output ptpd_pkg::ctx_type   out_ctx,
   output logic signed [32:0]  out_angle,
   output logic                out_negate
);

   // stage 1: scale by step
   logic signed [16:0] dt_s;
   logic signed [48:0] pf, ps, pt;
   logic signed [31:0] dx1_in, dy1_in, th1_in, dx1_ff, dy1_ff, th1_ff;
   logic v1_ff;

   assign dt_s = $signed({1'b0, time_step});
   assign pf = vel_forward * dt_s;
   assign ps = vel_side * dt_s;
   assign pt = vel_turn * dt_s;
   assign dx1_in = 32'((pf + 49'sd32768) >>> 16);
   assign dy1_in = 32'((ps + 49'sd32768) >>> 16);
   assign th1_in = 32'((pt + 49'sd32768) >>> 16);

   // stage 2: turn count estimate, series square
   logic [31:0] mag;
   logic signed [64:0] qp;
   logic signed [14:0] q2_in, q2_ff;
   logic [31:0] sq2_in, sq2_ff;
   logic series2_in, series2_ff, v2_ff;
   logic signed [31:0] dx2_ff, dy2_ff, th2_ff;

   assign mag = th1_ff[31] ? (~th1_ff + 32'd1) : th1_ff;
   assign series2_in = (th1_ff == 32'sd0) || (mag < {16'd0, limit});
   assign sq2_in = mag[15:0] * mag[15:0];
   assign qp = th1_ff * $signed({1'b0, ptpd_pkg::RECIP_TWO_PI});
   assign q2_in = $signed(qp[64:50]);

   // stage 3: remainder, divide square by 24
   logic signed [51:0] m3, qm;
   logic signed [39:0] r3_in, r3_ff;
   logic [60:0] sp;
   logic [27:0] ser3_in, ser3_ff;
   logic series3_ff, v3_ff;
   logic signed [31:0] dx3_ff, dy3_ff, th3_ff;

   assign m3 = {{4{th2_ff[31]}}, th2_ff, 16'd0};
   assign qm = q2_ff * ptpd_pkg::TWO_PI_W;
   assign r3_in = 40'(m3 - qm);
   assign sp = sq2_ff[31:3] * ptpd_pkg::RECIP_THREE;
   assign ser3_in = sp[60:33];

   // stage 4: correct remainder into (-pi, pi]
   logic signed [39:0] rc, r4_in, r4_ff;
   ptpd_pkg::ctx_type ctx4_in, ctx4_ff;
   logic v4_ff;

   always_comb begin
      if (r3_ff < 40'sd0) begin
         rc = r3_ff + ptpd_pkg::TWO_PI_R;
      end else if (r3_ff >= ptpd_pkg::TWO_PI_R) begin
         rc = r3_ff - ptpd_pkg::TWO_PI_R;
      end else begin
         rc = r3_ff;
      end
      r4_in = (rc > ptpd_pkg::PI_R) ? rc - ptpd_pkg::TWO_PI_R : rc;
      ctx4_in.dx = dx3_ff;
      ctx4_in.dy = dy3_ff;
      ctx4_in.th = th3_ff;
      ctx4_in.series = series3_ff;
      ctx4_in.ser_s = 31'(ptpd_pkg::Q30_ONE) - {3'd0, ser3_ff};
   end

   // stage 5: round to Q2.30 and fold into the right half plane
   logic signed [39:0] af;
   logic signed [32:0] a5_in, a5_ff;
   logic n5_in, n5_ff, v5_ff;
   ptpd_pkg::ctx_type ctx5_ff;

   always_comb begin
      af = (r4_ff + 40'sd2) >>> 2;
      if (af > ptpd_pkg::HALF_PI_R) begin
         a5_in = 33'(af - ptpd_pkg::PI_Q30_R);
         n5_in = 1'b1;
      end else if (af < -ptpd_pkg::HALF_PI_R) begin
         a5_in = 33'(af + ptpd_pkg::PI_Q30_R);
         n5_in = 1'b1;
      end else begin
         a5_in = 33'(af);
         n5_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx1_ff <= dx1_in;
         dy1_ff <= dy1_in;
         th1_ff <= th1_in;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         th2_ff <= th1_ff;
         q2_ff <= q2_in;
         sq2_ff <= sq2_in;
         series2_ff <= series2_in;
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
         th3_ff <= th2_ff;
         series3_ff <= series2_ff;
         r3_ff <= r3_in;
         ser3_ff <= ser3_in;
         r4_ff <= r4_in;
         ctx4_ff <= ctx4_in;
         a5_ff <= a5_in;
         n5_ff <= n5_in;
         ctx5_ff <= ctx4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_ctx = ctx5_ff;
   assign out_angle = a5_ff;
   assign out_negate = n5_ff;

endmodule

/* hw/rtl/ptpd_cordic.sv */
module ptpd_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  ptpd_pkg::ctx_type  in_ctx,
   input  logic signed [32:0] in_angle,
   input  logic               in_negate,
   output logic               out_valid,
   output ptpd_pkg::trig_type out_trig
);

   localparam int N = ptpd_pkg::TRIG_ITER;

   logic signed [33:0] x_ff [N];
   logic signed [33:0] y_ff [N];
   logic signed [32:0] a_ff [N];
   logic               v_ff [N];
   logic               n_ff [N];
   ptpd_pkg::ctx_type  ctx_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [33:0] x_cur, y_cur, x_in, y_in;
      logic signed [32:0] a_cur, a_in, at;
      logic v_cur, n_cur;
      ptpd_pkg::ctx_type ctx_cur;

      if (i == 0) begin : g_head
         assign x_cur = ptpd_pkg::CORDIC_X0;
         assign y_cur = 34'sd0;
         assign a_cur = in_angle;
         assign v_cur = in_valid;
         assign n_cur = in_negate;
         assign ctx_cur = in_ctx;
      end else begin : g_body
         assign x_cur = x_ff[i-1];
         assign y_cur = y_ff[i-1];
         assign a_cur = a_ff[i-1];
         assign v_cur = v_ff[i-1];
         assign n_cur = n_ff[i-1];
         assign ctx_cur = ctx_ff[i-1];
      end

      assign at = $signed({1'b0, ptpd_pkg::ATAN_Q30[i]});

      always_comb begin
         if (!a_cur[32]) begin
            x_in = x_cur - (y_cur >>> i);
            y_in = y_cur + (x_cur >>> i);
            a_in = a_cur - at;
         end else begin
            x_in = x_cur + (y_cur >>> i);
            y_in = y_cur - (x_cur >>> i);
            a_in = a_cur + at;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (adv) begin
            v_ff[i] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
            a_ff[i] <= a_in;
            n_ff[i] <= n_cur;
            ctx_ff[i] <= ctx_cur;
         end
      end
   end

   // undo the fold and clamp
   logic signed [33:0] xf, yf;
   ptpd_pkg::trig_type trig_in, trig_ff;
   logic vo_ff;

   always_comb begin
      xf = n_ff[N-1] ? -x_ff[N-1] : x_ff[N-1];
      yf = n_ff[N-1] ? -y_ff[N-1] : y_ff[N-1];
      trig_in.ctx = ctx_ff[N-1];
      trig_in.cs = ptpd_pkg::clamp_q30(xf);
      trig_in.sn = ptpd_pkg::clamp_q30(yf);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= v_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         trig_ff <= trig_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_trig = trig_ff;

endmodule

/* hw/rtl/ptpd_div.sv */
module ptpd_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  ptpd_pkg::trig_type in_trig,
   output logic               out_valid,
   output ptpd_pkg::coef_type out_coef
);

   localparam int N = ptpd_pkg::DIV_BITS;

   typedef struct packed {
      ptpd_pkg::trig_type trig;
      logic [31:0] den;
      logic [31:0] nsl;
      logic [31:0] ncl;
      logic [31:0] rs;
      logic [31:0] rc;
      logic [31:0] qs;
      logic [31:0] qc;
      logic        ovs;
      logic        ovc;
      logic        sgs;
      logic        sgc;
   } dstage_type;

   // front: operands, sign and overflow
   logic [30:0] sn_mag;
   logic [47:0] ns, nc;
   logic [32:0] cmc;
   logic [31:0] den;
   dstage_type  f_in, f_ff;
   logic        vf_ff;

   always_comb begin
      sn_mag = in_trig.sn[31] ? 31'(-in_trig.sn) : in_trig.sn[30:0];
      ns = {1'b0, sn_mag, 16'd0};
      cmc = 33'($signed({ptpd_pkg::Q30_ONE[31], ptpd_pkg::Q30_ONE})
               - $signed({in_trig.cs[31], in_trig.cs}));
      nc = {cmc[31:0], 16'd0};
      den = in_trig.ctx.th[31] ? (~in_trig.ctx.th + 32'd1) : in_trig.ctx.th;
      f_in.trig = in_trig;
      f_in.den = den;
      f_in.nsl = ns[31:0];
      f_in.ncl = nc[31:0];
      f_in.rs = {16'd0, ns[47:32]};
      f_in.rc = {16'd0, nc[47:32]};
      f_in.qs = 32'd0;
      f_in.qc = 32'd0;
      f_in.ovs = {16'd0, ns[47:32]} >= den;
      f_in.ovc = {16'd0, nc[47:32]} >= den;
      f_in.sgs = in_trig.sn[31] ^ in_trig.ctx.th[31];
      f_in.sgc = in_trig.ctx.th[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff <= 1'b0;
      end else if (adv) begin
         vf_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
      end
   end

   // one quotient bit per stage for both divisions
   dstage_type d_ff [N];
   logic       v_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_bit
      dstage_type cur, nxt;
      logic v_cur;
      logic [32:0] ts, tc;
      logic ges, gec;

      if (k == 0) begin : g_head
         assign cur = f_ff;
         assign v_cur = vf_ff;
      end else begin : g_body
         assign cur = d_ff[k-1];
         assign v_cur = v_ff[k-1];
      end

      always_comb begin
         nxt = cur;
         ts = {cur.rs, cur.nsl[N-1-k]};
         tc = {cur.rc, cur.ncl[N-1-k]};
         ges = ts >= {1'b0, cur.den};
         gec = tc >= {1'b0, cur.den};
         nxt.rs = ges ? 32'(ts - {1'b0, cur.den}) : ts[31:0];
         nxt.rc = gec ? 32'(tc - {1'b0, cur.den}) : tc[31:0];
         nxt.qs = {cur.qs[30:0], ges};
         nxt.qc = {cur.qc[30:0], gec};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            d_ff[k] <= nxt;
         end
      end
   end

   // clamp, apply sign, pick series forms for small angles
   dstage_type          last;
   logic [31:0]         ms, mc;
   ptpd_pkg::coef_type  coef_in, coef_ff;
   logic                vo_ff;

   always_comb begin
      last = d_ff[N-1];
      ms = (last.ovs || last.qs > 32'd1073741824) ? 32'd1073741824 : last.qs;
      mc = (last.ovc || last.qc > 32'd1073741824) ? 32'd1073741824 : last.qc;
      coef_in.dx = last.trig.ctx.dx;
      coef_in.dy = last.trig.ctx.dy;
      coef_in.cs = last.trig.cs;
      coef_in.sn = last.trig.sn;
      if (last.trig.ctx.series) begin
         coef_in.s = $signed({1'b0, last.trig.ctx.ser_s});
         coef_in.c = $signed({last.trig.ctx.th[18:0], 13'd0});
      end else begin
         coef_in.s = $signed(last.sgs ? (~ms + 32'd1) : ms);
         coef_in.c = $signed(last.sgc ? (~mc + 32'd1) : mc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= v_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         coef_ff <= coef_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_coef = coef_ff;

endmodule

/* hw/rtl/ptpd_rotate.sv */
module ptpd_rotate (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  ptpd_pkg::coef_type in_coef,
   output logic               out_valid,
   output logic signed [31:0] move_x,
   output logic signed [31:0] move_y,
   output logic signed [31:0] cos_turn,
   output logic signed [31:0] sin_turn,
   output logic               saturated
);

   // stage A: four products
   logic signed [63:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [31:0] csa_ff, sna_ff;
   logic va_ff;

   // stage B: sums with rounding bias
   logic signed [65:0] sx_in, sy_in, sx_ff, sy_ff;
   logic signed [31:0] csb_ff, snb_ff;
   logic vb_ff;

   assign sx_in = 66'(p1_ff) - 66'(p2_ff) + 66'sd536870912;
   assign sy_in = 66'(p3_ff) + 66'(p4_ff) + 66'sd536870912;

   // stage C: shift and saturate
   logic signed [65:0] rx, ry;
   logic ox, oy;
   logic signed [31:0] mx_in, my_in, mx_ff, my_ff, csc_ff, snc_ff;
   logic sat_ff, vc_ff;

   always_comb begin
      rx = sx_ff >>> 30;
      ry = sy_ff >>> 30;
      ox = !((&rx[65:31]) || !(|rx[65:31]));
      oy = !((&ry[65:31]) || !(|ry[65:31]));
      mx_in = ox ? (rx[65] ? 32'sh80000000 : 32'sh7fffffff) : rx[31:0];
      my_in = oy ? (ry[65] ? 32'sh80000000 : 32'sh7fffffff) : ry[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff <= in_coef.dx * in_coef.s;
         p2_ff <= in_coef.dy * in_coef.c;
         p3_ff <= in_coef.dx * in_coef.c;
         p4_ff <= in_coef.dy * in_coef.s;
         csa_ff <= in_coef.cs;
         sna_ff <= in_coef.sn;
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         csb_ff <= csa_ff;
         snb_ff <= sna_ff;
         mx_ff <= mx_in;
         my_ff <= my_in;
         sat_ff <= ox || oy;
         csc_ff <= csb_ff;
         snc_ff <= snb_ff;
      end
   end

   assign out_valid = vc_ff;
   assign move_x = mx_ff;
   assign move_y = my_ff;
   assign cos_turn = csc_ff;
   assign sin_turn = snc_ff;
   assign saturated = sat_ff;

endmodule

/* hw/rtl/planar_twist_to_pose_delta_top.sv */
// Planar twist to pose delta (SE(2) exponential map) in fixed point. Each item
// carries forward, sideways and turn velocity (Q16.16) and a step (Q0.16); the
// block returns the rotated translation (Q16.16), cosine and sine of the turn
// (Q2.30) and a flag set when either translation clipped. The pipeline takes
// one item per cycle unless it is stalled and passes it through scaling and
// angle reduction, the one-step-per-stage CORDIC, the two bit-per-stage
// dividers that form sin(t)/t and (1-cos t)/t, and then the final products,
// rounding and saturation. The whole pipeline holds while a result waits
// unaccepted on the rsp side, so req_ready follows rsp_ready whenever a
// result is pending. The register small_angle_limit (byte address 0,
// reset 1) sets the turn magnitude below which the series forms replace
// the division; write it only while idle.
module planar_twist_to_pose_delta_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_vel_forward,
   input  logic signed [31:0] req_vel_side,
   input  logic signed [31:0] req_vel_turn,
   input  logic [15:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_move_x,
   output logic signed [31:0] rsp_move_y,
   output logic signed [31:0] rsp_cos_turn,
   output logic signed [31:0] rsp_sin_turn,
   output logic               rsp_saturated,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   // Advance every stage together unless a finished item sits unaccepted.
   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Configuration register: the word index is paddr[2].
   logic [15:0] limit_ff;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= ptpd_pkg::SMALL_ANGLE_RESET;
      end else if (csr_wr && csr_paddr[2] == ptpd_pkg::CSR_IDX_SMALL_ANGLE) begin
         limit_ff <= csr_pwdata[15:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == ptpd_pkg::CSR_IDX_SMALL_ANGLE)
                       ? {16'd0, limit_ff} : 32'd0;

   // Scale by step, reduce the angle, fold it into the right half plane.
   logic              sc_valid;
   ptpd_pkg::ctx_type sc_ctx;
   logic signed [32:0] sc_angle;
   logic              sc_negate;

   ptpd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .vel_forward (req_vel_forward),
      .vel_side    (req_vel_side),
      .vel_turn    (req_vel_turn),
      .time_step   (req_time_step),
      .limit       (limit_ff),
      .out_valid   (sc_valid),
      .out_ctx     (sc_ctx),
      .out_angle   (sc_angle),
      .out_negate  (sc_negate)
   );

   // Cosine and sine, one rotation step per stage.
   logic               tr_valid;
   ptpd_pkg::trig_type tr_trig;

   ptpd_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sc_valid),
      .in_ctx    (sc_ctx),
      .in_angle  (sc_angle),
      .in_negate (sc_negate),
      .out_valid (tr_valid),
      .out_trig  (tr_trig)
   );

   // The two coefficients: divide, or take the series forms for small turns.
   logic               cf_valid;
   ptpd_pkg::coef_type cf_coef;

   ptpd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (tr_valid),
      .in_trig   (tr_trig),
      .out_valid (cf_valid),
      .out_coef  (cf_coef)
   );

   // Rotate the translation, round and saturate; holds the output item.
   ptpd_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cf_valid),
      .in_coef   (cf_coef),
      .out_valid (rsp_valid),
      .move_x    (rsp_move_x),
      .move_y    (rsp_move_y),
      .cos_turn  (rsp_cos_turn),
      .sin_turn  (rsp_sin_turn),
      .saturated (rsp_saturated)
   );

`ifndef NO_ASSERTIONS
   // A clipped item shows a rail value in at least one translation.
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_move_x == 32'sh7fffffff || rsp_move_x == 32'sh80000000 ||
         rsp_move_y == 32'sh7fffffff || rsp_move_y == 32'sh80000000)
      else $error("saturated without a clipped translation");

   // Cosine and sine stay within one in Q2.30.
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_cos_turn <= 32'sd1073741824 && rsp_cos_turn >= -32'sd1073741824 &&
         rsp_sin_turn <= 32'sd1073741824 && rsp_sin_turn >= -32'sd1073741824)
      else $error("trig output out of range");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled pipeline takes no new item.
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while output stalled");
`endif

endmodule
